// File: rtl/core/rrr_pkg.sv
// Shared constants, types and the remainder step of the random range reducer.
package rrr_pkg;

  // Width of the configured maximum and of the derived range.
  localparam int unsigned MaxValueBits = 8;
  localparam int unsigned RangeBits    = 9;
  localparam int unsigned RemBits      = 8;
  // Word bits consumed by one stage of the remainder pipeline.
  localparam int unsigned DigitBits    = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One restoring step: shift one bit into the remainder and reduce it once.
  // The remainder stays below the range, so one compare and subtract suffice.
  function automatic logic [RemBits-1:0] mod_step(input logic [RemBits-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [RangeBits-1:0] range);
    logic [RangeBits-1:0] t;
    t = {rem, bit_in};
    if (t >= range) begin
      t = t - range;
    end
    return t[RemBits-1:0];
  endfunction

endpackage

// File: rtl/core/random_range_reducer.sv
// Top level of the random range reducer: limit unit, front, queue and remainder pipeline.
// Throughput: one raw word per cycle; busy rises only while the limit is being computed.
// Path: an accepted word below the limit is held in the front register, then in the queue,
// then passes the 4-bit-per-stage remainder pipeline before its result strobes.
// Rejected words give no strobe. Results cannot be stalled.
// Reset and every max_value write start a limit computation over WORD_BITS bits,
// one remainder step per cycle, during which busy is high and no word is accepted.
module random_range_reducer #(
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned RESULT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [WORD_BITS-1:0]             random_word_i,
  input  logic                             max_value_we_i,
  input  logic [rrr_pkg::MaxValueBits-1:0] max_value_i,
  output logic                             strobe_o,
  output logic [RESULT_BITS-1:0]           bounded_value_o
);

  logic                          limit_running;
  logic [rrr_pkg::RangeBits-1:0] range;
  logic [WORD_BITS-1:0]          limit;
  rrr_pkg::queue_status_t        queue_status;
  logic                          push, pop;
  logic [WORD_BITS-1:0]          push_word, pop_word;

  rrr_limit #(
    .WORD_BITS  (WORD_BITS),
    .RESULT_BITS(RESULT_BITS)
  ) u_limit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (max_value_we_i),
    .cfg_data_i(max_value_i),
    .running_o (limit_running),
    .range_o   (range),
    .limit_o   (limit)
  );

  rrr_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .random_word_i  (random_word_i),
    .limit_running_i(limit_running),
    .limit_i        (limit),
    .queue_status_i (queue_status),
    .busy           (busy),
    .push_o         (push),
    .push_word_o    (push_word)
  );

  rrr_queue #(
    .WIDTH(WORD_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_word),
    .pop_i      (pop),
    .pop_data_o (pop_word),
    .status_o   (queue_status)
  );

  rrr_back #(
    .WORD_BITS  (WORD_BITS),
    .RESULT_BITS(RESULT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (queue_status),
    .word_i         (pop_word),
    .range_i        (range),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .bounded_value_o(bounded_value_o)
  );

endmodule

// File: rtl/core/rrr_limit.sv
// Holds the maximum value register and computes the acceptance limit one bit per cycle.
module rrr_limit #(
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned RESULT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrr_pkg::MaxValueBits-1:0]  cfg_data_i,
  output logic                              running_o,
  output logic [rrr_pkg::RangeBits-1:0]     range_o,
  output logic [WORD_BITS-1:0]              limit_o
);

  localparam int unsigned CntBits = $clog2(WORD_BITS);
  localparam logic [rrr_pkg::MaxValueBits-1:0] MaxMask =
    (RESULT_BITS >= rrr_pkg::MaxValueBits) ? {rrr_pkg::MaxValueBits{1'b1}}
                                           : rrr_pkg::MaxValueBits'((1 << RESULT_BITS) - 1);

  logic [rrr_pkg::MaxValueBits-1:0] max_q;
  logic                             running_q;
  logic [CntBits-1:0]               cnt_q;
  logic [rrr_pkg::RemBits-1:0]      rem_q, rem_d;
  logic [WORD_BITS-1:0]             limit_q;
  logic                             last;

  assign range_o   = {1'b0, max_q} + rrr_pkg::RangeBits'(1);
  assign running_o = running_q;
  assign limit_o   = limit_q;

  // The all-ones word is fed in bit by bit to get its remainder modulo the range.
  assign rem_d = rrr_pkg::mod_step(rem_q, 1'b1, range_o);
  assign last  = (cnt_q == CntBits'(WORD_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= MaxMask;
      running_q <= 1'b1;
      cnt_q     <= '0;
      rem_q     <= '0;
    end else if (cfg_we_i) begin
      max_q     <= cfg_data_i & MaxMask;
      running_q <= 1'b1;
      cnt_q     <= '0;
      rem_q     <= '0;
    end else if (running_q) begin
      rem_q <= rem_d;
      if (last) begin
        running_q <= 1'b0;
        cnt_q     <= '0;
      end else begin
        cnt_q <= cnt_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (running_q && last && !cfg_we_i) begin
      limit_q <= {WORD_BITS{1'b1}} - WORD_BITS'(rem_d);
    end
  end

  a_cnt_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> running_q)
    else $error("limit counter advanced while idle");

endmodule

// File: rtl/core/rrr_front.sv
// Accepts raw words, rejects those at or above the limit and forwards the rest to the queue.
module rrr_front #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [WORD_BITS-1:0]   random_word_i,
  input  logic                   limit_running_i,
  input  logic [WORD_BITS-1:0]   limit_i,
  input  rrr_pkg::queue_status_t queue_status_i,
  output logic                   busy,
  output logic                   push_o,
  output logic [WORD_BITS-1:0]   push_word_o
);

  logic                 valid_q;
  logic [WORD_BITS-1:0] word_q;
  logic                 take, keep, stalled;

  // The holding register stalls only while the queue is full.
  assign stalled     = valid_q && queue_status_i.full;
  assign busy        = limit_running_i || stalled;
  assign take        = start && !busy;
  assign keep        = take && (random_word_i < limit_i);
  assign push_o      = valid_q && !queue_status_i.full;
  assign push_word_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= keep || stalled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      word_q <= random_word_i;
    end
  end

endmodule

// File: rtl/core/rrr_queue.sv
// Two-entry queue between the classifying front and the remainder pipeline.
module rrr_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output rrr_pkg::queue_status_t status_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_pop;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && !status_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule

// File: rtl/core/rrr_back.sv
// Remainder pipeline: reduces each accepted word modulo the range, a few bits per stage.
module rrr_back #(
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned RESULT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrr_pkg::queue_status_t        queue_status_i,
  input  logic [WORD_BITS-1:0]          word_i,
  input  logic [rrr_pkg::RangeBits-1:0] range_i,
  output logic                          pop_o,
  output logic                          strobe_o,
  output logic [RESULT_BITS-1:0]        bounded_value_o
);

  localparam int unsigned Digit   = rrr_pkg::DigitBits;
  localparam int unsigned NStages = (WORD_BITS + Digit - 1) / Digit;
  localparam int unsigned PadBits = NStages * Digit;
  localparam int unsigned ExtBits = 16;

  logic                        valid_q [NStages];
  logic [rrr_pkg::RemBits-1:0] rem_q   [NStages];
  logic [rrr_pkg::RemBits-1:0] rem_d   [NStages];
  logic [PadBits-1:0]          word_q  [NStages];
  logic [PadBits-1:0]          word_d  [NStages];
  logic [ExtBits-1:0]          rem_ext;

  // The pipeline never stalls, so it drains the queue whenever it holds a word.
  assign pop_o = !queue_status_i.empty;

  // Stage s reduces digit NStages-1-s, most significant digit first.
  always_comb begin
    logic [rrr_pkg::RemBits-1:0] r;
    for (int s = 0; s < NStages; s++) begin
      if (s == 0) begin
        word_d[s] = PadBits'(word_i);
        r         = '0;
      end else begin
        word_d[s] = word_q[s-1];
        r         = rem_q[s-1];
      end
      for (int d = 0; d < Digit; d++) begin
        r = rrr_pkg::mod_step(r, word_d[s][(NStages-1-s)*Digit + (Digit-1-d)], range_i);
      end
      rem_d[s] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStages; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      valid_q[0] <= pop_o;
      for (int s = 1; s < NStages; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NStages; s++) begin
      rem_q[s]  <= rem_d[s];
      word_q[s] <= word_d[s];
    end
  end

  assign rem_ext         = ExtBits'(rem_q[NStages-1]);
  assign strobe_o        = valid_q[NStages-1];
  assign bounded_value_o = rem_ext[RESULT_BITS-1:0];

  a_strobe_follows_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(valid_q[0], NStages - 1))
    else $error("result strobe without a matching pipeline entry");

endmodule

// File: test/tb_random_range_reducer.sv
// Self-checking testbench for the random range reducer: rejection limit and modulo checks.
`timescale 1ns / 1ps

module tb_random_range_reducer;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned RESULT_BITS  = 8;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned PhaseCount   = 10;
  localparam int unsigned PhaseWords   = 165;

  // Tracks the configured maximum and the bounded values still owed by the block.
  class range_reduction_model;
    logic [rrr_pkg::MaxValueBits-1:0] max_value;
    logic [RESULT_BITS-1:0]           pending_values[$];
    int unsigned                      mismatches;

    function new();
      max_value  = 8'd255;
      mismatches = 0;
    endfunction

    // Largest multiple of the range that does not exceed the all-ones word.
    function logic [WORD_BITS-1:0] accept_limit();
      logic [WORD_BITS-1:0]          all_ones;
      logic [rrr_pkg::RangeBits-1:0] range_len;
      all_ones  = '1;
      range_len = {1'b0, max_value} + 1'b1;
      return all_ones - (all_ones % range_len);
    endfunction

    function void note_word(logic [WORD_BITS-1:0] word);
      logic [rrr_pkg::RangeBits-1:0] range_len;
      logic [WORD_BITS-1:0]          remainder;
      range_len = {1'b0, max_value} + 1'b1;
      if (word < accept_limit()) begin
        remainder = word % range_len;
        pending_values.push_back(remainder[RESULT_BITS-1:0]);
      end
    endfunction

    function void check_value(logic [RESULT_BITS-1:0] actual);
      logic [RESULT_BITS-1:0] expected;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        mismatches++;
      end else begin
        expected = pending_values.pop_front();
        if (actual !== expected) begin
          $display("%0t: bounded_value mismatch, expected %0d, actual %0d",
                   $time, expected, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic [WORD_BITS-1:0]             random_word_i;
  logic                             max_value_we_i;
  logic [rrr_pkg::MaxValueBits-1:0] max_value_i;
  logic                             strobe_o;
  logic [RESULT_BITS-1:0]           bounded_value_o;

  range_reduction_model board;
  int unsigned          quiet_cycles = 0;

  random_range_reducer #(
    .WORD_BITS  (WORD_BITS),
    .RESULT_BITS(RESULT_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .random_word_i  (random_word_i),
    .max_value_we_i (max_value_we_i),
    .max_value_i    (max_value_i),
    .strobe_o       (strobe_o),
    .bounded_value_o(bounded_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Values are sampled before the edge updates them, so this sees what the block saw.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        board.note_word(random_word_i);
      end
      if (strobe_o) begin
        board.check_value(bounded_value_o);
      end
      if ((start && !busy) || strobe_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("random_range_reducer test failed");
        $finish;
      end
    end
  end

  // Holds start high until the block takes the word.
  task automatic send_word(input logic [WORD_BITS-1:0] word);
    start         <= 1'b1;
    random_word_i <= word;
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  task automatic idle_cycles(input int unsigned count);
    start <= 1'b0;
    repeat (count) begin
      random_word_i <= $urandom;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (board.pending_values.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Rejected words leave no trace in the queue, so let the pipeline empty before writing.
  task automatic write_max(input logic [rrr_pkg::MaxValueBits-1:0] value);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    max_value_we_i <= 1'b1;
    max_value_i    <= value;
    @(posedge clk_i);
    max_value_we_i  <= 1'b0;
    board.max_value = value;
  endtask

  initial begin
    logic [rrr_pkg::MaxValueBits-1:0] phase_max [PhaseCount];
    logic [WORD_BITS-1:0]             word;
    logic [WORD_BITS-1:0]             limit;
    bit                               steady;

    board          = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    random_word_i  = '0;
    max_value_we_i = 1'b0;
    max_value_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset range of 256 divides 2^32, yet the top 256 words are still rejected.
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FEFF);
    send_word(32'hFFFF_FF00);
    send_word(32'h8000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);

    // With a range of one only the all-ones word is rejected.
    write_max(8'd0);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFF);
    send_word(32'h1234_5678);

    write_max(8'd6);
    limit = board.accept_limit();
    send_word(limit - 1'b1);
    send_word(limit);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0007);

    phase_max[0] = 8'd1;
    phase_max[1] = 8'd255;
    phase_max[2] = 8'd128;
    phase_max[3] = 8'd2;
    phase_max[4] = 8'h55;
    phase_max[5] = 8'hAA;
    phase_max[6] = 8'($urandom_range(0, 255));
    phase_max[7] = 8'($urandom_range(0, 255));
    phase_max[8] = 8'd0;
    phase_max[9] = 8'($urandom_range(3, 254));

    for (int p = 0; p < PhaseCount; p++) begin
      write_max(phase_max[p]);
      limit  = board.accept_limit();
      steady = (p == 3);
      for (int n = 0; n < PhaseWords; n++) begin
        if (!steady && $urandom_range(0, 99) < 3) begin
          idle_cycles($urandom_range(1, 4));
        end
        if (!steady && $urandom_range(0, 199) == 0) begin
          drain_results();
        end
        case ($urandom_range(0, 9))
          0: word = limit - $urandom_range(1, 4);
          1: word = limit + $urandom_range(0, 3);
          2: word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: word = $urandom;
        endcase
        send_word(word);
      end
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_values.size() == 0) begin
      $display("random_range_reducer test passed");
    end else begin
      if (board.pending_values.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time,
                 board.pending_values.size());
      end
      $display("random_range_reducer test failed");
    end
    $finish;
  end

endmodule
